// ===== hdl/xtea_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA package
// Types, constants and the round mixing function of the XTEA cipher engine.
// ----------------------------------------------------------------------------
package xtea_pkg;

  localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;

  localparam logic [31:0] KEY_RESET_0 = 32'hF8E9_EBDE;
  localparam logic [31:0] KEY_RESET_1 = 32'h53CE_00F7;
  localparam logic [31:0] KEY_RESET_2 = 32'h2FE1_2FE3;
  localparam logic [31:0] KEY_RESET_3 = 32'h04DC_EE29;
  localparam logic [7:0]  ROUNDS_RESET = 8'd32;

  localparam int WORD_W  = 32;
  localparam int ROUND_W = 8;
  localparam int INDEX_W = 3;

  typedef enum logic [INDEX_W-1:0] {
    REG_KEY_0  = 3'd0,
    REG_KEY_1  = 3'd1,
    REG_KEY_2  = 3'd2,
    REG_KEY_3  = 3'd3,
    REG_ROUNDS = 3'd4
  } reg_index_t;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_HALF_A = 2'd1,
    ST_HALF_B = 2'd2,
    ST_FLUSH  = 2'd3
  } state_t;

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] x);
    return ((x << 4) ^ (x >> 5)) + x;
  endfunction

endpackage : xtea_pkg
`default_nettype wire

// ===== hdl/xtea_block_cipher_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// XTEA block cipher engine
// Encrypts or decrypts one 64-bit block with a 128-bit key and a programmable
// number of rounds.
// ----------------------------------------------------------------------------
// One shared half-round unit does all the work, one Feistel half round per
// clock. A block is taken when the engine is idle; it then runs two half
// rounds per round and waits in the flush state until the output register
// is free. The engine is ready for the next block in the same cycle that
// the result enters the output register; the default is 32 rounds. With a
// round count of zero the block passes through unchanged.
// The output register holds a finished result until it is taken, while the
// engine is free to accept and work on the next block.
module xtea_block_cipher_top
  import xtea_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [2*WORD_W-1:0]  s_axis_tdata,   // block_word_0, block_word_1
  input  wire logic                 s_axis_tuser,   // opcode
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [2*WORD_W-1:0]       m_axis_tdata,   // result_word_0, result_word_1
  input  wire logic                 cfg_wen,
  input  wire logic [INDEX_W-1:0]   cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data
);

  state_t             state;
  state_t             state_next;
  logic [WORD_W-1:0]  key [4];
  logic [ROUND_W-1:0] round_count;
  logic [ROUND_W-1:0] count;
  opcode_t            op;
  logic [WORD_W-1:0]  v0;
  logic [WORD_W-1:0]  v1;
  logic [WORD_W-1:0]  sum;
  logic [WORD_W-1:0]  res0;
  logic [WORD_W-1:0]  res1;
  logic               out_valid;

  logic               in_xfer;
  logic               out_free;
  logic               tgt_is_v1;
  logic               run;
  logic               last_round;
  logic [WORD_W-1:0]  unit_x;
  logic [WORD_W-1:0]  unit_t;
  logic [1:0]         key_sel;
  logic [WORD_W-1:0]  unit_f;
  logic [WORD_W-1:0]  unit_res;
  logic [WORD_W-1:0]  sum_init;

  assign in_xfer    = s_axis_tvalid && s_axis_tready;
  assign out_free   = !out_valid || m_axis_tready;
  assign last_round = (count == ROUND_W'(1));
  assign sum_init   = (opcode_t'(s_axis_tuser) == OP_DECRYPT) ?
                      WORD_W'(XTEA_DELTA * WORD_W'(round_count)) : '0;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = (round_count == '0) ? ST_FLUSH : ST_HALF_A;
        end
      end
      ST_HALF_A: state_next = ST_HALF_B;
      ST_HALF_B: state_next = last_round ? ST_FLUSH : ST_HALF_A;
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    run           = 1'b0;
    tgt_is_v1     = 1'b0;
    case (state)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_HALF_A: begin
        run       = 1'b1;
        tgt_is_v1 = (op == OP_DECRYPT);
      end
      ST_HALF_B: begin
        run       = 1'b1;
        tgt_is_v1 = (op == OP_ENCRYPT);
      end
      default: ;
    endcase
  end

  always_comb begin
    unit_x   = tgt_is_v1 ? v0 : v1;
    unit_t   = tgt_is_v1 ? v1 : v0;
    key_sel  = tgt_is_v1 ? sum[12:11] : sum[1:0];
    unit_f   = mix(unit_x) ^ (sum + key[key_sel]);
    unit_res = (op == OP_DECRYPT) ? (unit_t - unit_f) : (unit_t + unit_f);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      state <= state_next;
      if (in_xfer) begin
        count <= round_count;
      end else if (state == ST_HALF_B) begin
        count <= count - ROUND_W'(1);
      end
      if (state == ST_FLUSH && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0]      <= KEY_RESET_0;
      key[1]      <= KEY_RESET_1;
      key[2]      <= KEY_RESET_2;
      key[3]      <= KEY_RESET_3;
      round_count <= ROUNDS_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_KEY_0:  key[0] <= cfg_data;
        REG_KEY_1:  key[1] <= cfg_data;
        REG_KEY_2:  key[2] <= cfg_data;
        REG_KEY_3:  key[3] <= cfg_data;
        REG_ROUNDS: round_count <= cfg_data[ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op  <= opcode_t'(s_axis_tuser);
      v0  <= s_axis_tdata[WORD_W-1:0];
      v1  <= s_axis_tdata[2*WORD_W-1:WORD_W];
      sum <= sum_init;
    end else if (run) begin
      if (tgt_is_v1) begin
        v1 <= unit_res;
      end else begin
        v0 <= unit_res;
      end
      if (state == ST_HALF_A) begin
        sum <= (op == OP_DECRYPT) ? (sum - XTEA_DELTA) : (sum + XTEA_DELTA);
      end
    end
    if (state == ST_FLUSH && out_free) begin
      res0 <= v0;
      res1 <= v1;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {res1, res0};

`ifndef SYNTH
  a_rise_after_flush: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_FLUSH)
    else $error("result became valid without a finished block");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HALF_A || state == ST_HALF_B) |-> count != '0)
    else $error("round counter empty while rounds are running");

  a_zero_rounds: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && round_count == '0) |=> state == ST_FLUSH)
    else $error("zero-round block did not go straight to the output");

  a_half_pair: assert property (@(posedge clk) disable iff (rst)
    state == ST_HALF_A |=> state == ST_HALF_B)
    else $error("first half round not followed by the second");

  a_decrypt_sum: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HALF_B && last_round && op == OP_DECRYPT) |=> sum == '0)
    else $error("decryption sum did not return to zero");
`endif

endmodule : xtea_block_cipher_top
`default_nettype wire

// ===== tb/xtea_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher checker
// Watches the configuration port and both stream channels. It keeps its own
// copy of the key and round count, computes the cipher result of every block
// transfer, and compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module xtea_checker
  import xtea_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  input  wire logic [2*WORD_W-1:0] s_axis_tdata,   // block_word_0, block_word_1
  input  wire logic                s_axis_tuser,   // opcode
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [2*WORD_W-1:0] m_axis_tdata,   // result_word_0, result_word_1
  input  wire logic                cfg_wen,
  input  wire logic [INDEX_W-1:0]  cfg_index,
  input  wire logic [WORD_W-1:0]   cfg_data,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic [WORD_W-1:0] word_1;
    logic [WORD_W-1:0] word_0;
  } block_t;

  logic [WORD_W-1:0]  key [4];
  logic [ROUND_W-1:0] rounds;
  block_t             expected_blocks [$];
  int                 fails = 0;

  function automatic block_t xtea_transform(input opcode_t op, input block_t blk);
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] t;
    block_t            res;
    v0 = blk.word_0;
    v1 = blk.word_1;
    if (op == OP_ENCRYPT) begin
      sum = '0;
      for (int i = 0; i < rounds; i++) begin
        t = ((v1 << 4) ^ (v1 >> 5)) + v1;
        v0 = v0 + (t ^ (sum + key[sum[1:0]]));
        sum = sum + XTEA_DELTA;
        t = ((v0 << 4) ^ (v0 >> 5)) + v0;
        v1 = v1 + (t ^ (sum + key[sum[12:11]]));
      end
    end else begin
      sum = XTEA_DELTA * rounds;
      for (int i = 0; i < rounds; i++) begin
        t = ((v0 << 4) ^ (v0 >> 5)) + v0;
        v1 = v1 - (t ^ (sum + key[sum[12:11]]));
        sum = sum - XTEA_DELTA;
        t = ((v1 << 4) ^ (v1 >> 5)) + v1;
        v0 = v0 - (t ^ (sum + key[sum[1:0]]));
      end
    end
    res.word_0 = v0;
    res.word_1 = v1;
    return res;
  endfunction

  always @(posedge clk) begin
    block_t got;
    block_t want;
    if (rst) begin
      key[0] = KEY_RESET_0;
      key[1] = KEY_RESET_1;
      key[2] = KEY_RESET_2;
      key[3] = KEY_RESET_3;
      rounds = ROUNDS_RESET;
      expected_blocks.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_blocks.push_back(xtea_transform(opcode_t'(s_axis_tuser),
                                                 block_t'(s_axis_tdata)));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = block_t'(m_axis_tdata);
        if (expected_blocks.size() == 0) begin
          $display("%0t: result transfer %h arrived with no block outstanding",
                   $time, got);
          fails++;
        end else begin
          want = expected_blocks.pop_front();
          if (got.word_0 !== want.word_0 || got.word_1 !== want.word_1) begin
            fails++;
            if (got.word_0 !== want.word_0) begin
              $display("%0t: result_word_0 expected %h actual %h",
                       $time, want.word_0, got.word_0);
            end
            if (got.word_1 !== want.word_1) begin
              $display("%0t: result_word_1 expected %h actual %h",
                       $time, want.word_1, got.word_1);
            end
          end
        end
      end
      if (cfg_wen) begin
        case (cfg_index)
          REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3: key[cfg_index[1:0]] = cfg_data;
          REG_ROUNDS: rounds = cfg_data[ROUND_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= expected_blocks.size();
    fail_count <= fails;
  end

endmodule

// ===== tb/tb_xtea_block_cipher_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA block cipher engine testbench
// Drives blocks to encrypt and decrypt under several keys and round counts,
// from a directed set of edge cases to long random runs, with bursty input,
// a stalling receiver and one long receiver hold-off. A checker beside the
// engine predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_xtea_block_cipher_top;
  import xtea_pkg::*;

  localparam int RESET_CYCLES    = 9;
  localparam int HOLD_OFF_CYCLES = 700;
  localparam int STALL_LIMIT     = 5000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int RANDOM_PHASES   = 8;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [2*WORD_W-1:0] s_axis_tdata = '0;   // block_word_0, block_word_1
  logic                s_axis_tuser = 1'b0; // opcode
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [2*WORD_W-1:0] m_axis_tdata;        // result_word_0, result_word_1
  logic                cfg_wen = 1'b0;
  logic [INDEX_W-1:0]  cfg_index = '0;
  logic [WORD_W-1:0]   cfg_data = '0;

  int fail_count;
  int pending;
  int burst_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  xtea_block_cipher_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  xtea_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_block(input opcode_t op, input logic [WORD_W-1:0] w0,
                            input logic [WORD_W-1:0] w1);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w1, w0};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(20, 60);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                           input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
                           input logic [WORD_W-1:0] rounds_word, input bit spare);
    set_reg(REG_KEY_0, k0);
    set_reg(REG_KEY_1, k1);
    set_reg(REG_KEY_2, k2);
    set_reg(REG_KEY_3, k3);
    set_reg(REG_ROUNDS, rounds_word);
    if (spare) begin
      for (int idx = REG_ROUNDS + 1; idx < (1 << INDEX_W); idx++) begin
        set_reg(idx[INDEX_W-1:0], '1);
      end
    end
    cfg_wen <= 1'b0;
  endtask

  // The receiver first holds off long enough for the engine to fill up.
  initial begin : result_sink
    int span;
    int mode;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(1, 150);
      repeat (span) begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("** xtea_block_cipher_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [ROUND_W-1:0] round_total;
    int                 item_total;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset key and the default round count.
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_DECRYPT, '1, '1);
    send_block(OP_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(OP_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA);
    send_block(OP_ENCRYPT, 32'h8000_0000, 32'h0000_0001);
    send_block(OP_DECRYPT, 32'h0000_0001, 32'h8000_0000);

    // Zero rounds, set through a write with the upper bits set.
    drain();
    configure('0, '0, '0, '0, 32'hFFFF_FF00, 1'b0);
    send_block(OP_ENCRYPT, $urandom, $urandom);
    send_block(OP_DECRYPT, $urandom, $urandom);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '0, '0);

    // Largest round count with an all-ones key.
    drain();
    configure('1, '1, '1, '1, 32'h0000_00FF, 1'b0);
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '1, '1);

    // One round, followed by writes to indexes that hold no register.
    drain();
    configure($urandom, $urandom, $urandom, $urandom, 32'h0000_0101, 1'b1);
    send_block(OP_ENCRYPT, $urandom, $urandom);
    send_block(OP_DECRYPT, $urandom, $urandom);
    send_block(OP_ENCRYPT, '0, '1);
    send_block(OP_DECRYPT, '1, '0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: round_total = ROUNDS_RESET;
        1: round_total = 8'd0;
        2: round_total = 8'd255;
        3: round_total = 8'd1;
        default: round_total = $urandom_range(2, 48);
      endcase
      item_total = (round_total > 64) ? 12 : 230;
      drain();
      configure(rand_word(), rand_word(), rand_word(), rand_word(),
                ($urandom & 32'hFFFF_FF00) | round_total, phase[0]);
      for (int n = 0; n < item_total; n++) begin
        send_block(opcode_t'($urandom_range(0, 1)), rand_word(), rand_word());
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("** xtea_block_cipher_top: PASSED **");
    end else begin
      $display("** xtea_block_cipher_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/xtea_pkg.sv
hdl/xtea_block_cipher_top.sv
tb/xtea_checker.sv
tb/tb_xtea_block_cipher_top.sv
